### rtl/core/tws_pkg.sv
// shared types and constants for the three-wire serial master
`timescale 1ns / 1ps

package tws_pkg;

   // default field widths
   localparam int unsigned AddressBitsDefault = 7;
   localparam int unsigned DataBitsDefault    = 16;

   // frame phase codes
   localparam logic [3:0] PH_IDLE  = 4'd0;
   localparam logic [3:0] PH_LEAD  = 4'd1;
   localparam logic [3:0] PH_DCARE = 4'd2;
   localparam logic [3:0] PH_RBIT  = 4'd3;
   localparam logic [3:0] PH_ADDR  = 4'd4;
   localparam logic [3:0] PH_WDATA = 4'd5;
   localparam logic [3:0] PH_TURN  = 4'd6;
   localparam logic [3:0] PH_RDATA = 4'd7;
   localparam logic [3:0] PH_TRAIL = 4'd8;

   // pin levels and status for one tick
   typedef struct packed {
      logic sclk;
      logic sdata_out;
      logic sdata_drive;
      logic enable_n;
      logic busy;
      logic read_valid;
   } tws_pins_type;

endpackage

### rtl/core/tws_frame.sv
// frame sequencer: phase, bit count, shift word and readback accumulator
`timescale 1ns / 1ps

module tws_frame #(
   parameter int unsigned ADDRESS_BITS = tws_pkg::AddressBitsDefault,
   parameter int unsigned DATA_BITS    = tws_pkg::DataBitsDefault
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic                      start_req,
   input  logic                      is_read,
   input  logic [ADDRESS_BITS-1:0]   address,
   input  logic [DATA_BITS-1:0]      write_data,
   input  logic                      sdata_in,
   output tws_pkg::tws_pins_type     pins,
   output logic [DATA_BITS-1:0]      readback_word
);
   import tws_pkg::*;

   localparam int unsigned WordW  = ADDRESS_BITS + DATA_BITS;
   localparam int unsigned MaxLen = (ADDRESS_BITS > DATA_BITS) ? ADDRESS_BITS : DATA_BITS;
   localparam int unsigned CntW   = $clog2(MaxLen + 1);

   logic [3:0]           phase_ff, phase_in;
   logic [CntW-1:0]      cnt_ff, cnt_in;
   logic [WordW-1:0]     shift_ff, shift_in;
   logic                 rflag_ff, rflag_in;
   logic                 level_ff, level_in;
   logic [DATA_BITS-1:0] acc_ff, acc_in;

   logic                 start;
   logic [3:0]           cur_phase;
   logic [CntW-1:0]      cur_cnt, cnt_inc, phase_len;
   logic [WordW-1:0]     cur_shift;
   logic                 cur_rflag, cur_level, active;
   logic [DATA_BITS-1:0] cur_acc;

   // a start tick in idle latches the frame and already drives its first level
   assign start     = (phase_ff == PH_IDLE) && start_req;
   assign cur_phase = start ? PH_LEAD : phase_ff;
   assign cur_cnt   = start ? '0 : cnt_ff;
   assign cur_shift = start ? {address, write_data} : shift_ff;
   assign cur_rflag = start ? is_read : rflag_ff;
   assign cur_level = start ? 1'b0 : level_ff;
   assign cur_acc   = (start && is_read) ? '0 : acc_ff;
   assign active    = (cur_phase != PH_IDLE) && (cur_phase <= PH_TRAIL);
   assign cnt_inc   = cur_cnt + 1'b1;

   // bits in the current phase
   always_comb begin
      case (cur_phase)
         PH_ADDR:            phase_len = CntW'(ADDRESS_BITS);
         PH_WDATA, PH_RDATA: phase_len = CntW'(DATA_BITS);
         default:            phase_len = CntW'(1);
      endcase
   end

   // pin levels and next state for this tick
   always_comb begin
      pins          = '0;
      pins.sdata_drive = 1'b1;
      pins.enable_n = 1'b1;
      phase_in      = cur_phase;
      cnt_in        = cur_cnt;
      shift_in      = cur_shift;
      rflag_in      = cur_rflag;
      level_in      = cur_level;
      acc_in        = cur_acc;
      if (active) begin
         pins.busy        = 1'b1;
         pins.sclk        = ~cur_level;
         pins.enable_n    = (cur_phase == PH_LEAD) || (cur_phase == PH_TRAIL);
         pins.sdata_drive = !((cur_phase == PH_TURN) || (cur_phase == PH_RDATA));
         if (cur_phase == PH_RBIT) begin
            pins.sdata_out = cur_rflag;
         end else if ((cur_phase == PH_ADDR) || (cur_phase == PH_WDATA)) begin
            pins.sdata_out = cur_shift[WordW-1];
         end
         if (cur_level) begin
            // low half: sample, shift and count
            if (cur_phase == PH_RDATA) begin
               acc_in = (cur_acc << 1) | DATA_BITS'(sdata_in);
            end
            if ((cur_phase == PH_ADDR) || (cur_phase == PH_WDATA)) begin
               shift_in = cur_shift << 1;
            end
            cnt_in   = cnt_inc;
            level_in = 1'b0;
            if (cnt_inc >= phase_len) begin
               cnt_in = '0;
               case (cur_phase)
                  PH_LEAD:  phase_in = PH_DCARE;
                  PH_DCARE: phase_in = PH_RBIT;
                  PH_RBIT:  phase_in = PH_ADDR;
                  PH_ADDR:  phase_in = cur_rflag ? PH_TURN : PH_WDATA;
                  PH_WDATA: phase_in = PH_TRAIL;
                  PH_TURN:  phase_in = PH_RDATA;
                  PH_RDATA: phase_in = PH_TRAIL;
                  PH_TRAIL: begin
                     phase_in        = PH_IDLE;
                     pins.read_valid = cur_rflag;
                  end
                  default:  phase_in = PH_IDLE;
               endcase
            end
         end else begin
            level_in = 1'b1;
         end
      end else begin
         phase_in = PH_IDLE;
         level_in = 1'b0;
         cnt_in   = '0;
      end
   end

   assign readback_word = acc_in;

   // state advances on each accepted tick
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         cnt_ff   <= '0;
         shift_ff <= '0;
         rflag_ff <= 1'b0;
         level_ff <= 1'b0;
         acc_ff   <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         shift_ff <= shift_in;
         rflag_ff <= rflag_in;
         level_ff <= level_in;
         acc_ff   <= acc_in;
      end
   end

endmodule

### rtl/core/three_wire_serial_master.sv
// top level of the three-wire serial master
`timescale 1ns / 1ps
//
// Each req_ transfer is one half-period tick of the serial clock. While
// idle, a tick with req_start_req high latches read/write, address and
// write data and starts a frame; start requests during a frame are ignored.
// Every accepted tick yields exactly one rsp_ transfer with the sclk,
// enable_n and data pin levels for that tick, plus busy, the readback
// word and a read_valid strobe on the last tick of a read frame.
// The result of a tick is registered and shown in the cycle after it is accepted.
// The master takes one tick per cycle while the receiver does not stall; the
// sequencer updates its phase, bit count and shift registers once per tick.
// The result register frees req_ready whenever it is empty or being taken,
// so a new tick is accepted in the same cycle the previous result leaves.
// If the receiver stalls, the result holds and req_ready drops until it is
// taken; no tick is lost or duplicated.
// Reset (synchronous, active high) returns the sequencer to idle with the
// readback word cleared and empties the result register.
//
module three_wire_serial_master #(
   parameter int unsigned ADDRESS_BITS = tws_pkg::AddressBitsDefault,
   parameter int unsigned DATA_BITS    = tws_pkg::DataBitsDefault
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_start_req,
   input  logic                    req_is_read,
   input  logic [ADDRESS_BITS-1:0] req_address,
   input  logic [DATA_BITS-1:0]    req_write_data,
   input  logic                    req_sdata_in,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_sclk,
   output logic                    rsp_sdata_out,
   output logic                    rsp_sdata_drive,
   output logic                    rsp_enable_n,
   output logic                    rsp_busy_res,
   output logic [DATA_BITS-1:0]    rsp_read_data,
   output logic                    rsp_read_valid
);
   import tws_pkg::*;

   logic                 step;
   logic                 valid_ff, valid_in;
   tws_pins_type         pins_ff, pins_in;
   logic [DATA_BITS-1:0] rdata_ff, rdata_in;

   assign req_ready = !valid_ff || rsp_ready;
   assign step      = req_valid && req_ready;

   tws_frame #(
      .ADDRESS_BITS (ADDRESS_BITS),
      .DATA_BITS    (DATA_BITS)
   ) u_frame (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .start_req     (req_start_req),
      .is_read       (req_is_read),
      .address       (req_address),
      .write_data    (req_write_data),
      .sdata_in      (req_sdata_in),
      .pins          (pins_in),
      .readback_word (rdata_in)
   );

   // result register
   assign valid_in = step || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         pins_ff  <= pins_in;
         rdata_ff <= rdata_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_sclk        = pins_ff.sclk;
   assign rsp_sdata_out   = pins_ff.sdata_out;
   assign rsp_sdata_drive = pins_ff.sdata_drive;
   assign rsp_enable_n    = pins_ff.enable_n;
   assign rsp_busy_res    = pins_ff.busy;
   assign rsp_read_data   = rdata_ff;
   assign rsp_read_valid  = pins_ff.read_valid;

endmodule

### rtl/core/tws_checker.sv
// port-level checks for the three-wire serial master
`timescale 1ns / 1ps

module tws_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_sclk,
   input logic rsp_sdata_out,
   input logic rsp_sdata_drive,
   input logic rsp_enable_n,
   input logic rsp_busy_res,
   input logic rsp_read_valid
);

   // a stalled result stays presented
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("stalled result dropped");

   // input only backs up behind a waiting result
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |-> rsp_valid)
      else $error("input stalled with empty result register");

   // released pin reads as low
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_sdata_drive |-> !rsp_sdata_out && rsp_busy_res && !rsp_enable_n)
      else $error("data pin released outside a read frame");

   // idle ticks keep the bus quiet
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_busy_res |-> rsp_enable_n && !rsp_sclk && !rsp_read_valid)
      else $error("bus activity while idle");

   // read strobe only on the trailing low tick
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_read_valid |-> rsp_busy_res && rsp_enable_n && !rsp_sclk)
      else $error("read strobe outside trailing clock");

endmodule

bind three_wire_serial_master tws_checker u_tws_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_sclk        (rsp_sclk),
   .rsp_sdata_out   (rsp_sdata_out),
   .rsp_sdata_drive (rsp_sdata_drive),
   .rsp_enable_n    (rsp_enable_n),
   .rsp_busy_res    (rsp_busy_res),
   .rsp_read_valid  (rsp_read_valid)
);

### tb/tb_three_wire_serial_master.sv
// self-checking testbench for the three-wire serial master tick sequencer
`timescale 1ns / 1ps

module tb_three_wire_serial_master;
   import tws_pkg::*;

   localparam int unsigned AW          = AddressBitsDefault;
   localparam int unsigned DW          = DataBitsDefault;
   localparam int unsigned STALL_LIMIT = 1000;
   localparam int unsigned PHASE_TICKS = 150;

   typedef struct packed {
      logic          start_req;
      logic          is_read;
      logic [AW-1:0] address;
      logic [DW-1:0] write_data;
      logic          sdata_in;
   } serial_tick_type;

   typedef struct packed {
      tws_pins_type  pins;
      logic [DW-1:0] readback;
   } tick_levels_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   logic          req_start_req = 1'b0;
   logic          req_is_read = 1'b0;
   logic [AW-1:0] req_address = '0;
   logic [DW-1:0] req_write_data = '0;
   logic          req_sdata_in = 1'b0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   logic          rsp_sclk;
   logic          rsp_sdata_out;
   logic          rsp_sdata_drive;
   logic          rsp_enable_n;
   logic          rsp_busy_res;
   logic [DW-1:0] rsp_read_data;
   logic          rsp_read_valid;

   three_wire_serial_master dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_start_req   (req_start_req),
      .req_is_read     (req_is_read),
      .req_address     (req_address),
      .req_write_data  (req_write_data),
      .req_sdata_in    (req_sdata_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_sclk        (rsp_sclk),
      .rsp_sdata_out   (rsp_sdata_out),
      .rsp_sdata_drive (rsp_sdata_drive),
      .rsp_enable_n    (rsp_enable_n),
      .rsp_busy_res    (rsp_busy_res),
      .rsp_read_data   (rsp_read_data),
      .rsp_read_valid  (rsp_read_valid)
   );

   // pending ticks, expected pin levels, bookkeeping
   serial_tick_type pending_ticks[$];
   tick_levels_type expected_levels[$];
   int unsigned  sender_idle_pct   = 19;
   int unsigned  receiver_idle_pct = 60;
   bit           tick_taken = 1'b0;
   int unsigned  mismatches = 0;
   int unsigned  ticks_checked = 0;
   int unsigned  read_frames = 0;
   int unsigned  write_frames = 0;
   int unsigned  readback_strobes = 0;
   int unsigned  stall_cycles = 0;

   // sequencer state of the predictor
   logic [3:0]       seq_phase;
   logic [4:0]       seq_count;
   logic [AW+DW-1:0] seq_shift;
   logic             seq_read;
   logic             seq_low_half;
   logic [DW-1:0]    seq_readback;

   // clock generation
   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic [4:0] phase_ticks_len(input logic [3:0] ph);
      if (ph == PH_ADDR) return 5'(AW);
      if (ph == PH_WDATA || ph == PH_RDATA) return 5'(DW);
      return 5'd1;
   endfunction

   function automatic logic [3:0] following_phase(input logic [3:0] ph, input logic rd);
      case (ph)
         PH_LEAD:  return PH_DCARE;
         PH_DCARE: return PH_RBIT;
         PH_RBIT:  return PH_ADDR;
         PH_ADDR:  return rd ? PH_TURN : PH_WDATA;
         PH_WDATA: return PH_TRAIL;
         PH_TURN:  return PH_RDATA;
         PH_RDATA: return PH_TRAIL;
         default:  return PH_IDLE;
      endcase
   endfunction

   // advance the predicted sequencer by one half-clock tick
   task automatic predict_tick(input serial_tick_type t, output tick_levels_type r);
      logic [3:0] ph;
      logic       dout;
      r = '0;
      r.pins.sdata_drive = 1'b1;
      r.pins.enable_n = 1'b1;
      dout = 1'b0;
      if (seq_phase == PH_IDLE && t.start_req) begin
         seq_read = t.is_read;
         seq_shift = {t.address, t.write_data};
         if (seq_read) begin
            seq_readback = '0;
            read_frames++;
         end else begin
            write_frames++;
         end
         seq_phase = PH_LEAD;
         seq_count = '0;
         seq_low_half = 1'b0;
      end
      if (seq_phase != PH_IDLE && seq_phase <= PH_TRAIL) begin
         ph = seq_phase;
         r.pins.busy = 1'b1;
         r.pins.sclk = ~seq_low_half;
         r.pins.enable_n = (ph == PH_LEAD || ph == PH_TRAIL);
         r.pins.sdata_drive = !(ph == PH_TURN || ph == PH_RDATA);
         if (ph == PH_RBIT)
            dout = seq_read;
         else if (ph == PH_ADDR || ph == PH_WDATA)
            dout = seq_shift[AW+DW-1];
         if (seq_low_half) begin
            if (ph == PH_RDATA)
               seq_readback = {seq_readback[DW-2:0], t.sdata_in};
            if (ph == PH_ADDR || ph == PH_WDATA)
               seq_shift = seq_shift << 1;
            seq_count++;
            if (seq_count >= phase_ticks_len(ph)) begin
               seq_count = '0;
               if (ph == PH_TRAIL) r.pins.read_valid = seq_read;
               seq_phase = following_phase(ph, seq_read);
            end
            seq_low_half = 1'b0;
         end else begin
            seq_low_half = 1'b1;
         end
      end else begin
         seq_phase = PH_IDLE;
         seq_low_half = 1'b0;
         seq_count = '0;
      end
      r.pins.sdata_out = dout & r.pins.sdata_drive;
      r.readback = seq_readback;
   endtask

   task automatic check_field(input string name, input logic [DW-1:0] want,
                              input logic [DW-1:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   task automatic queue_tick(input logic start, input logic rd, input logic [AW-1:0] addr,
                             input logic [DW-1:0] wdata, input logic sdin);
      serial_tick_type t;
      t.start_req = start;
      t.is_read = rd;
      t.address = addr;
      t.write_data = wdata;
      t.sdata_in = sdin;
      pending_ticks.push_back(t);
   endtask

   // one whole frame: start tick, then the remaining ticks; the read word is
   // placed on the low tick of each read data clock, other pin levels random
   task automatic queue_frame(input logic rd, input logic [AW-1:0] addr,
                              input logic [DW-1:0] wdata, input logic [DW-1:0] word,
                              input bit junk_starts);
      int unsigned clocks;
      int unsigned k;
      logic        sdin;
      logic        junk;
      clocks = rd ? (4 + AW + DW + 1) : (4 + AW + DW);
      for (int unsigned i = 0; i < 2 * clocks; i++) begin
         k = i / 2;
         sdin = 1'($urandom_range(1));
         if (rd && (i % 2 == 1) && k >= 4 + AW && k < 4 + AW + DW)
            sdin = word[DW-1-(k-4-AW)];
         if (i == 0) begin
            queue_tick(1'b1, rd, addr, wdata, sdin);
         end else begin
            junk = junk_starts && ($urandom_range(3) == 0);
            queue_tick(junk, 1'($urandom_range(1)), AW'($urandom), DW'($urandom), sdin);
         end
      end
   endtask

   // idle ticks with random fields, start not requested
   task automatic queue_idle_ticks(input int unsigned n);
      for (int unsigned i = 0; i < n; i++)
         queue_tick(1'b0, 1'($urandom_range(1)), AW'($urandom), DW'($urandom),
                    1'($urandom_range(1)));
   endtask

   task automatic queue_random_traffic(input int unsigned target);
      int unsigned first;
      first = pending_ticks.size();
      while (pending_ticks.size() - first < target) begin
         if ($urandom_range(9) == 0)
            queue_idle_ticks($urandom_range(4, 1));
         else if ($urandom_range(1) == 0)
            queue_idle_ticks($urandom_range(3));
         queue_frame(1'($urandom_range(1)), AW'($urandom), DW'($urandom), DW'($urandom),
                     $urandom_range(1));
      end
   endtask

   task automatic wait_for_drain();
      while (pending_ticks.size() != 0 || req_valid || expected_levels.size() != 0)
         @(posedge clock);
   endtask

   // tick driver, inputs change on the falling edge
   always @(negedge clock) begin : drive_ticks
      serial_tick_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
         if (!req_valid || tick_taken) begin
            if (pending_ticks.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               nxt = pending_ticks.pop_front();
               req_start_req  <= nxt.start_req;
               req_is_read    <= nxt.is_read;
               req_address    <= nxt.address;
               req_write_data <= nxt.write_data;
               req_sdata_in   <= nxt.sdata_in;
               req_valid      <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each result transfer, then predict the accepted tick
   always @(posedge clock) begin : watch_transfers
      serial_tick_type t;
      tick_levels_type want;
      tick_levels_type got;
      if (reset) begin
         tick_taken = 1'b0;
         seq_phase = PH_IDLE;
         seq_count = '0;
         seq_shift = '0;
         seq_read = 1'b0;
         seq_low_half = 1'b0;
         seq_readback = '0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.pins.sclk = rsp_sclk;
            got.pins.sdata_out = rsp_sdata_out;
            got.pins.sdata_drive = rsp_sdata_drive;
            got.pins.enable_n = rsp_enable_n;
            got.pins.busy = rsp_busy_res;
            got.pins.read_valid = rsp_read_valid;
            got.readback = rsp_read_data;
            if (expected_levels.size() == 0) begin
               mismatches++;
               $display("%0t: result transfer with no tick pending, expected none, actual %0h",
                        $time, got);
            end else begin
               want = expected_levels.pop_front();
               ticks_checked++;
               if (got.pins.read_valid === 1'b1) readback_strobes++;
               check_field("sclk", DW'(want.pins.sclk), DW'(got.pins.sclk));
               check_field("sdata_out", DW'(want.pins.sdata_out), DW'(got.pins.sdata_out));
               check_field("sdata_drive", DW'(want.pins.sdata_drive),
                           DW'(got.pins.sdata_drive));
               check_field("enable_n", DW'(want.pins.enable_n), DW'(got.pins.enable_n));
               check_field("busy_res", DW'(want.pins.busy), DW'(got.pins.busy));
               check_field("readback word", want.readback, got.readback);
               check_field("read_valid", DW'(want.pins.read_valid), DW'(got.pins.read_valid));
            end
         end
         tick_taken = req_valid && req_ready;
         if (tick_taken) begin
            t.start_req = req_start_req;
            t.is_read = req_is_read;
            t.address = req_address;
            t.write_data = req_write_data;
            t.sdata_in = req_sdata_in;
            predict_tick(t, want);
            expected_levels.push_back(want);
         end
      end
   end

   // watchdog on cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // stimulus sequence
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed frames: field extremes, start while busy, back-to-back starts
      queue_tick(1'b0, 1'b1, '1, '1, 1'b1);
      queue_tick(1'b0, 1'b0, '0, '0, 1'b0);
      queue_frame(1'b0, '1, '1, '0, 1'b0);
      queue_frame(1'b0, '0, '0, '0, 1'b1);
      queue_idle_ticks(2);
      queue_frame(1'b1, AW'('h55), '0, '1, 1'b0);
      queue_frame(1'b1, AW'('h2A), '1, '0, 1'b1);
      queue_frame(1'b1, '1, '1, DW'('hA5C3), 1'b1);
      queue_frame(1'b0, AW'('h01), DW'('h8001), '0, 1'b0);
      queue_idle_ticks(1);
      wait_for_drain();

      // sender lightly idle, receiver heavily stalled
      queue_random_traffic(PHASE_TICKS);
      wait_for_drain();

      // swapped idling
      sender_idle_pct = 60;
      receiver_idle_pct = 19;
      queue_random_traffic(PHASE_TICKS);
      wait_for_drain();

      // full rate on both sides
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      queue_random_traffic(PHASE_TICKS);
      wait_for_drain();
      repeat (10) @(posedge clock);

      if (expected_levels.size() != 0) begin
         mismatches++;
         $display("%0t: %0d expected results never arrived", $time, expected_levels.size());
      end
      $display("checked %0d ticks: %0d write frames, %0d read frames, %0d readback strobes",
               ticks_checked, write_frames, read_frames, readback_strobes);
      $display("three stall profiles with a full drain between them, %0d mismatches",
               mismatches);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/core/tws_pkg.sv
rtl/core/tws_frame.sv
rtl/core/three_wire_serial_master.sv
rtl/core/tws_checker.sv
tb/tb_three_wire_serial_master.sv
